// ===== rtl/text_console_writer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// text_console_writer_unit_macros.svh
// Assertion macros for the text console writer; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define TCW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tcw assertion failed");

// expression must never be true outside reset
`define TCW_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tcw forbidden condition seen");

`else

`define TCW_ASSERT(lbl, clk, rst, prop)
`define TCW_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== rtl/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

   // screen geometry
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = ROWS * COLS;

   // widths of the transaction fields
   localparam int CURSOR_W = 11;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int BYTE_W   = 8;
   localparam int CELL_W   = 2 * BYTE_W;

   // internal widths
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CCOL_W  = $clog2(COLS);

   localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h0F;

   typedef enum logic [1:0] {
      FUNC_PUT       = 2'd0,
      FUNC_BACKSPACE = 2'd1,
      FUNC_CLEAR     = 2'd2,
      FUNC_READ      = 2'd3
   } func_type;

   // cell store access for one cycle
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
   } ram_req_type;

endpackage

// ===== rtl/tcw_cell_ram.sv =====
// ---------------------------------------------------------------------------
// tcw_cell_ram
// Character cell store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tcw_cell_ram (
   input  logic                        clock,
   input  tcw_pkg::ram_req_type        ram_req,
   output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// ---------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor tracking, scroll and clear sweeps, cell reads.
// ---------------------------------------------------------------------------
`include "text_console_writer_unit_macros.svh"

module tcw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]     req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]     req_read_col,
   input  logic [tcw_pkg::BYTE_W-1:0]    text_attr,
   output logic                          rsp_valid,
   output logic [tcw_pkg::CURSOR_W-1:0]  rsp_cursor_cell,
   output logic [tcw_pkg::BYTE_W-1:0]    rsp_read_char,
   output logic [tcw_pkg::BYTE_W-1:0]    rsp_read_attr,
   output tcw_pkg::ram_req_type          ram_req,
   input  logic [tcw_pkg::CELL_W-1:0]    ram_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_SCROLL,
      ST_FILL
   } state_type;

   state_type                       state_ff, state_in;
   tcw_pkg::func_type               func_ff, func_in;
   logic [tcw_pkg::BYTE_W-1:0]      char_ff, char_in;
   logic [tcw_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [tcw_pkg::COL_W-1:0]       col_ff, col_in;
   logic [tcw_pkg::CURSOR_W-1:0]    cursor_ff, cursor_in;
   logic [tcw_pkg::CCOL_W-1:0]      ccol_ff, ccol_in;
   logic [tcw_pkg::CURSOR_W-1:0]    scan_ff, scan_in;
   logic                            pend_ff, pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CURSOR_W-1:0]    rsp_cursor_ff, rsp_cursor_in;
   logic [tcw_pkg::BYTE_W-1:0]      rsp_char_ff, rsp_char_in;
   logic [tcw_pkg::BYTE_W-1:0]      rsp_attr_ff, rsp_attr_in;
   logic [tcw_pkg::CELL_W-1:0]      blank_cell;
   logic                            read_in_range;
   logic [tcw_pkg::CURSOR_W-1:0]    read_index;
   logic                            cursor_at_end;

   assign blank_cell    = {text_attr, tcw_pkg::BLANK_CHAR};
   assign read_in_range = (32'(row_ff) < tcw_pkg::ROWS) && (32'(col_ff) < tcw_pkg::COLS);
   assign read_index    = tcw_pkg::CURSOR_W'(32'(row_ff) * tcw_pkg::COLS + 32'(col_ff));
   assign cursor_at_end = (cursor_ff == tcw_pkg::CURSOR_W'(tcw_pkg::CELLS));

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      char_in       = char_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cursor_in     = cursor_ff;
      ccol_in       = ccol_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      ram_req       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in  = tcw_pkg::func_type'(req_func);
               char_in  = req_char_code;
               row_in   = req_read_row;
               col_in   = req_read_col;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_char_in = '0;
            rsp_attr_in = '0;
            unique case (func_ff)
               tcw_pkg::FUNC_PUT: begin
                  if (char_ff == '0) begin
                     state_in = ST_IDLE;
                  end else if (cursor_at_end) begin
                     // past the end: move rows up before the put
                     scan_in  = tcw_pkg::CURSOR_W'(tcw_pkg::COLS);
                     pend_in  = 1'b0;
                     state_in = ST_SCROLL;
                  end else if (char_ff == tcw_pkg::NEWLINE_CHAR) begin
                     cursor_in = tcw_pkg::CURSOR_W'(cursor_ff
                                 - tcw_pkg::CURSOR_W'(ccol_ff)
                                 + tcw_pkg::CURSOR_W'(tcw_pkg::COLS));
                     ccol_in   = '0;
                     state_in  = ST_IDLE;
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = tcw_pkg::ADDR_W'(cursor_ff);
                     ram_req.wr_data = {text_attr, char_ff};
                     cursor_in       = tcw_pkg::CURSOR_W'(cursor_ff + 1'b1);
                     ccol_in = (ccol_ff == tcw_pkg::CCOL_W'(tcw_pkg::COLS - 1)) ? '0
                               : tcw_pkg::CCOL_W'(ccol_ff + 1'b1);
                     state_in = ST_IDLE;
                  end
               end
               tcw_pkg::FUNC_BACKSPACE: begin
                  if (cursor_ff != '0) begin
                     cursor_in       = tcw_pkg::CURSOR_W'(cursor_ff - 1'b1);
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = tcw_pkg::ADDR_W'(cursor_in);
                     ram_req.wr_data = blank_cell;
                     ccol_in = (ccol_ff == '0) ? tcw_pkg::CCOL_W'(tcw_pkg::COLS - 1)
                               : tcw_pkg::CCOL_W'(ccol_ff - 1'b1);
                  end
                  state_in = ST_IDLE;
               end
               tcw_pkg::FUNC_CLEAR: begin
                  scan_in  = '0;
                  state_in = ST_FILL;
               end
               tcw_pkg::FUNC_READ: begin
                  if (read_in_range) begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = tcw_pkg::ADDR_W'(read_index);
                     state_in        = ST_READ_WAIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
            rsp_valid_in = (state_in == ST_IDLE);
         end
         ST_READ_WAIT: begin
            rsp_char_in  = ram_rd_data[tcw_pkg::BYTE_W-1:0];
            rsp_attr_in  = ram_rd_data[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            // read one row below, write back the cell fetched last cycle
            ram_req.rd_en   = (scan_ff != tcw_pkg::CURSOR_W'(tcw_pkg::CELLS));
            ram_req.rd_addr = tcw_pkg::ADDR_W'(scan_ff);
            ram_req.wr_en   = pend_ff;
            ram_req.wr_addr = tcw_pkg::ADDR_W'(scan_ff
                              - tcw_pkg::CURSOR_W'(tcw_pkg::COLS + 1));
            ram_req.wr_data = ram_rd_data;
            pend_in         = ram_req.rd_en;
            if (ram_req.rd_en) begin
               scan_in = tcw_pkg::CURSOR_W'(scan_ff + 1'b1);
            end else begin
               scan_in  = tcw_pkg::CURSOR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            // blank sweep up to the last cell: bottom row for scroll, all for clear
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = tcw_pkg::ADDR_W'(scan_ff);
            ram_req.wr_data = blank_cell;
            scan_in         = tcw_pkg::CURSOR_W'(scan_ff + 1'b1);
            if (scan_ff == tcw_pkg::CURSOR_W'(tcw_pkg::CELLS - 1)) begin
               if (func_ff == tcw_pkg::FUNC_CLEAR) begin
                  cursor_in     = '0;
                  ccol_in       = '0;
                  rsp_char_in   = '0;
                  rsp_attr_in   = '0;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  // scroll done: cursor drops one row, then the put runs again
                  cursor_in = tcw_pkg::CURSOR_W'(cursor_ff
                              - tcw_pkg::CURSOR_W'(tcw_pkg::COLS));
                  state_in  = ST_EXEC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_cursor_in = rsp_valid_in ? cursor_in : rsp_cursor_ff;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         ccol_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         ccol_ff      <= ccol_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      char_ff       <= char_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      scan_ff       <= scan_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_cell = rsp_cursor_ff;
   assign rsp_read_char   = rsp_char_ff;
   assign rsp_read_attr   = rsp_attr_ff;

   // checks
   `TCW_NEVER(a_cursor_range, clock, reset, cursor_ff > tcw_pkg::CURSOR_W'(tcw_pkg::CELLS))
   `TCW_ASSERT(a_col_match, clock, reset, cursor_at_end |-> (ccol_ff == '0))
   `TCW_ASSERT(a_rsp_idle, clock, reset, rsp_valid_ff |-> (state_ff == ST_IDLE))
   `TCW_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `TCW_NEVER(a_wr_range, clock, reset, ram_req.wr_en && (32'(ram_req.wr_addr) >= tcw_pkg::CELLS))

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// ---------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine: cell store, cursor, scroll, clear and cell read.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with rsp_valid, and it must be captured
// then since the receiver cannot stall it. Put character and backspace give
// their result from the execute state, a cell read from the read wait state
// (from the execute state when the addressed cell lies off the screen).
// Clear walks the whole store one cell per cycle. A put at the past-end
// cursor first scrolls: one copy pass through the single cell-store read port
// and a bottom-row blank. The next command may be started in the cycle the
// result strobe is high. Write csr_wr_data to set the attribute byte only
// while no command is in flight; the store content is undefined until the
// first clear.
// ---------------------------------------------------------------------------
module text_console_writer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]     req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]     req_read_col,
   output logic                          rsp_valid,
   output logic [tcw_pkg::CURSOR_W-1:0]  rsp_cursor_cell,
   output logic [tcw_pkg::BYTE_W-1:0]    rsp_read_char,
   output logic [tcw_pkg::BYTE_W-1:0]    rsp_read_attr,
   input  logic                          csr_wr_en,
   input  logic [tcw_pkg::BYTE_W-1:0]    csr_wr_data
);

   logic [tcw_pkg::BYTE_W-1:0]  text_attr_ff, text_attr_in;
   tcw_pkg::ram_req_type        ram_req;
   logic [tcw_pkg::CELL_W-1:0]  ram_rd_data;

   // attribute register
   assign text_attr_in = csr_wr_en ? csr_wr_data : text_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= tcw_pkg::ATTR_RESET;
      end else begin
         text_attr_ff <= text_attr_in;
      end
   end

   // sequencer
   tcw_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_read_row    (req_read_row),
      .req_read_col    (req_read_col),
      .text_attr       (text_attr_ff),
      .rsp_valid       (rsp_valid),
      .rsp_cursor_cell (rsp_cursor_cell),
      .rsp_read_char   (rsp_read_char),
      .rsp_read_attr   (rsp_read_attr),
      .ram_req         (ram_req),
      .ram_rd_data     (ram_rd_data)
   );

   // cell store
   tcw_cell_ram u_cell_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

endmodule
